[rtl/core/qtes_pkg.sv]
package qtes_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned NUM_EFFECTS = 10;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_PLAY  = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_BEGIN = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_ON   = 2'd1,
    EV_OFF  = 2'd2
  } tone_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [3:0]  effect_id;
    logic [31:0] now_ms;
    logic        muted;
  } in_t;

  typedef struct packed {
    logic        accepted;
    tone_e       tone_event;
    logic [15:0] tone_hz;
    logic        busy_res;
    logic [2:0]  queued;
  } out_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic       clear;
    logic [3:0] data;
  } qctl_t;

  typedef struct packed {
    logic [3:0]        head_data;
    logic [QCNT_W-1:0] count;
    logic              full;
    logic              empty;
  } qstat_t;

  function automatic logic [15:0] step_hz(input logic [4:0] idx);
    logic [15:0] hz;
    case (idx)
      5'd0:    hz = 16'd2000;
      5'd1:    hz = 16'd2600;
      5'd2:    hz = 16'd3300;
      5'd3:    hz = 16'd180;
      5'd4:    hz = 16'd880;
      5'd5:    hz = 16'd1175;
      5'd6:    hz = 16'd1568;
      5'd7:    hz = 16'd2093;
      5'd8:    hz = 16'd2637;
      5'd9:    hz = 16'd2637;
      5'd10:   hz = 16'd2093;
      5'd11:   hz = 16'd1568;
      5'd12:   hz = 16'd1175;
      5'd13:   hz = 16'd880;
      5'd14:   hz = 16'd2200;
      5'd15:   hz = 16'd0;
      5'd16:   hz = 16'd2200;
      5'd17:   hz = 16'd3100;
      5'd18:   hz = 16'd420;
      5'd19:   hz = 16'd2600;
      5'd20:   hz = 16'd520;
      5'd21:   hz = 16'd3400;
      5'd22:   hz = 16'd330;
      5'd23:   hz = 16'd3600;
      5'd24:   hz = 16'd1046;
      5'd25:   hz = 16'd1318;
      5'd26:   hz = 16'd1568;
      5'd27:   hz = 16'd2093;
      5'd28:   hz = 16'd2637;
      default: hz = 16'd0;
    endcase
    return hz;
  endfunction

  function automatic logic [7:0] step_ms(input logic [4:0] idx);
    logic [7:0] ms;
    case (idx)
      5'd0:                      ms = 8'd60;
      5'd1, 5'd2:                ms = 8'd25;
      5'd3:                      ms = 8'd140;
      5'd4, 5'd5, 5'd6, 5'd7,
      5'd8, 5'd9, 5'd10, 5'd11,
      5'd12, 5'd13:              ms = 8'd40;
      5'd14, 5'd15, 5'd16:       ms = 8'd45;
      5'd17, 5'd18, 5'd19,
      5'd20, 5'd21, 5'd22:       ms = 8'd25;
      5'd23:                     ms = 8'd12;
      5'd24, 5'd25, 5'd26,
      5'd27:                     ms = 8'd45;
      5'd28:                     ms = 8'd140;
      default:                   ms = 8'd0;
    endcase
    return ms;
  endfunction

  function automatic logic [4:0] eff_first(input logic [3:0] eff);
    logic [4:0] first;
    case (eff)
      4'd1:    first = 5'd0;
      4'd2:    first = 5'd1;
      4'd3:    first = 5'd3;
      4'd4:    first = 5'd4;
      4'd5:    first = 5'd9;
      4'd6:    first = 5'd14;
      4'd7:    first = 5'd17;
      4'd8:    first = 5'd23;
      4'd9:    first = 5'd24;
      default: first = 5'd0;
    endcase
    return first;
  endfunction

  function automatic logic [2:0] eff_count(input logic [3:0] eff);
    logic [2:0] cnt;
    case (eff)
      4'd1:    cnt = 3'd1;
      4'd2:    cnt = 3'd2;
      4'd3:    cnt = 3'd1;
      4'd4:    cnt = 3'd5;
      4'd5:    cnt = 3'd5;
      4'd6:    cnt = 3'd3;
      4'd7:    cnt = 3'd6;
      4'd8:    cnt = 3'd1;
      4'd9:    cnt = 3'd5;
      default: cnt = 3'd0;
    endcase
    return cnt;
  endfunction

endpackage

[rtl/core/qtes_queue.sv]
module qtes_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  qtes_pkg::qctl_t ctl_i,
  output qtes_pkg::qstat_t stat_o
);

  logic [3:0]                  store_q [qtes_pkg::QUEUE_DEPTH];
  logic [qtes_pkg::QIDX_W-1:0] head_q, head_d;
  logic [qtes_pkg::QCNT_W-1:0] count_q, count_d;
  logic [qtes_pkg::QCNT_W:0]   tail_sum;
  logic [qtes_pkg::QIDX_W-1:0] tail;

  always_comb begin
    tail_sum = (qtes_pkg::QCNT_W + 1)'(head_q) + (qtes_pkg::QCNT_W + 1)'(count_q);
    if (tail_sum >= (qtes_pkg::QCNT_W + 1)'(qtes_pkg::QUEUE_DEPTH)) begin
      tail_sum = tail_sum - (qtes_pkg::QCNT_W + 1)'(qtes_pkg::QUEUE_DEPTH);
    end
    tail = qtes_pkg::QIDX_W'(tail_sum);
  end

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (ctl_i.clear) begin
      head_d  = '0;
      count_d = '0;
    end else if (ctl_i.push) begin
      count_d = count_q + 1'b1;
    end else if (ctl_i.pop) begin
      count_d = count_q - 1'b1;
      if (head_q == qtes_pkg::QIDX_W'(qtes_pkg::QUEUE_DEPTH - 1)) begin
        head_d = '0;
      end else begin
        head_d = head_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push && !ctl_i.clear) begin
      store_q[tail] <= ctl_i.data;
    end
  end

  assign stat_o.head_data = store_q[head_q];
  assign stat_o.count     = count_q;
  assign stat_o.full      = (count_q == qtes_pkg::QCNT_W'(qtes_pkg::QUEUE_DEPTH));
  assign stat_o.empty     = (count_q == '0);

endmodule

[rtl/core/qtes_player.sv]
module qtes_player (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  qtes_pkg::in_t    word_i,
  input  qtes_pkg::qstat_t qstat_i,
  output qtes_pkg::qctl_t  qctl_o,
  output qtes_pkg::out_t   res_o
);

  logic [3:0]  cur_q, cur_d;
  logic [2:0]  step_q, step_d;
  logic [31:0] stamp_q, stamp_d;
  logic        pin_q, pin_d;

  logic [4:0]  first;
  logic [4:0]  cur_idx;
  logic [7:0]  dur;
  logic [31:0] elapsed;
  logic [3:0]  next_step;
  logic        start_step;
  logic [4:0]  start_idx;
  logic [15:0] start_hz;
  logic [qtes_pkg::QCNT_W-1:0] count_after;

  always_comb begin
    first     = qtes_pkg::eff_first(cur_q);
    cur_idx   = first + 5'(step_q);
    dur       = qtes_pkg::step_ms(cur_idx);
    elapsed   = word_i.now_ms - stamp_q;
    next_step = 4'(step_q) + 4'd1;

    cur_d      = cur_q;
    step_d     = step_q;
    stamp_d    = stamp_q;
    pin_d      = pin_q;
    start_step = 1'b0;
    start_idx  = '0;
    start_hz   = '0;
    qctl_o     = '0;
    qctl_o.data = word_i.effect_id;
    res_o      = '0;
    res_o.tone_event = qtes_pkg::EV_NONE;

    case (word_i.cmd)
      qtes_pkg::CMD_TICK: begin
        if (word_i.muted) begin
          qctl_o.clear = 1'b1;
          if (cur_q != '0 || pin_q) begin
            cur_d  = '0;
            step_d = '0;
            pin_d  = 1'b0;
            res_o.tone_event = qtes_pkg::EV_OFF;
          end
        end else if (cur_q == '0) begin
          if (!qstat_i.empty) begin
            qctl_o.pop = 1'b1;
            cur_d      = qstat_i.head_data;
            step_d     = '0;
            stamp_d    = word_i.now_ms;
            start_step = 1'b1;
            start_idx  = qtes_pkg::eff_first(qstat_i.head_data);
          end
        end else if (elapsed >= 32'(dur)) begin
          if (next_step >= 4'(qtes_pkg::eff_count(cur_q))) begin
            cur_d  = '0;
            step_d = '0;
            pin_d  = 1'b0;
            res_o.tone_event = qtes_pkg::EV_OFF;
          end else begin
            step_d     = 3'(next_step);
            stamp_d    = word_i.now_ms;
            start_step = 1'b1;
            start_idx  = first + 5'(next_step);
          end
        end
      end
      qtes_pkg::CMD_PLAY: begin
        if (word_i.effect_id != 4'd0 && word_i.effect_id < 4'(qtes_pkg::NUM_EFFECTS) &&
            !word_i.muted && !qstat_i.full) begin
          qctl_o.push    = 1'b1;
          res_o.accepted = 1'b1;
        end
      end
      qtes_pkg::CMD_STOP: begin
        qctl_o.clear = 1'b1;
        if (cur_q != '0 || pin_q) begin
          cur_d  = '0;
          step_d = '0;
          pin_d  = 1'b0;
          res_o.tone_event = qtes_pkg::EV_OFF;
        end
      end
      qtes_pkg::CMD_BEGIN: begin
        qctl_o.clear = 1'b1;
        cur_d   = '0;
        step_d  = '0;
        stamp_d = '0;
        pin_d   = 1'b0;
        res_o.tone_event = qtes_pkg::EV_OFF;
      end
      default: begin
        res_o.tone_event = qtes_pkg::EV_NONE;
      end
    endcase

    if (start_step) begin
      start_hz = qtes_pkg::step_hz(start_idx);
      if (start_hz == 16'd0) begin
        pin_d = 1'b0;
        res_o.tone_event = qtes_pkg::EV_OFF;
      end else begin
        pin_d = 1'b1;
        res_o.tone_event = qtes_pkg::EV_ON;
        res_o.tone_hz    = start_hz;
      end
    end

    if (qctl_o.clear) begin
      count_after = '0;
    end else if (qctl_o.push) begin
      count_after = qstat_i.count + 1'b1;
    end else if (qctl_o.pop) begin
      count_after = qstat_i.count - 1'b1;
    end else begin
      count_after = qstat_i.count;
    end

    res_o.busy_res = (cur_d != '0);
    res_o.queued   = 3'(count_after);

    if (!fire_i) begin
      qctl_o.push  = 1'b0;
      qctl_o.pop   = 1'b0;
      qctl_o.clear = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= '0;
      step_q  <= '0;
      stamp_q <= '0;
      pin_q   <= 1'b0;
    end else if (fire_i) begin
      cur_q   <= cur_d;
      step_q  <= step_d;
      stamp_q <= stamp_d;
      pin_q   <= pin_d;
    end
  end

endmodule

[rtl/core/queued_tone_effect_sequencer.sv]
// Flow: a word in the input register has its result word registered in the result
// register when that register is empty or being drained, then offered at the output.
// Throughput: one word per cycle while the output is not stalled; the queue access, step
// table lookup and 32-bit elapsed time compare all fit between input and result registers.
// Reset: rst_ni clears the queue pointers, the playing effect, its step index and stamp, the
// pin flag and both pipeline valid flags; the queue storage itself is not cleared.
module queued_tone_effect_sequencer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  qtes_pkg::in_t  in_word_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output qtes_pkg::out_t out_word_o
);

  logic             s1_valid_q, s1_valid_d;
  qtes_pkg::in_t    s1_word_q;
  logic             res_valid_q, res_valid_d;
  qtes_pkg::out_t   res_q;
  qtes_pkg::out_t   res_d;
  qtes_pkg::qctl_t  qctl;
  qtes_pkg::qstat_t qstat;
  logic             res_ready;
  logic             fire;
  logic             in_take;

  assign res_ready  = !res_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && res_ready;
  assign in_stall_o = s1_valid_q && !res_ready;
  assign in_take    = in_valid_i && !in_stall_o;

  qtes_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (qctl),
    .stat_o (qstat)
  );

  qtes_player u_player (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .word_i  (s1_word_q),
    .qstat_i (qstat),
    .qctl_o  (qctl),
    .res_o   (res_d)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_take) begin
      s1_valid_d = 1'b1;
    end else if (fire) begin
      s1_valid_d = 1'b0;
    end
    res_valid_d = res_valid_q;
    if (fire) begin
      res_valid_d = 1'b1;
    end else if (res_valid_q && !out_stall_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_word_q <= in_word_i;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_word_o  = res_q;

  a_no_fire_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && out_stall_i) |-> !fire)
    else $error("input register advanced while the result word was stalled");

  a_accept_fills_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && res_d.accepted) |=> !qstat.empty)
    else $error("accepted play left the queue empty");

  a_tone_on_has_freq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && res_d.tone_event == qtes_pkg::EV_ON) |-> res_d.tone_hz != 16'd0)
    else $error("tone on reported with zero frequency");

  a_begin_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && s1_word_q.cmd == qtes_pkg::CMD_BEGIN) |=>
      (qstat.empty && !res_q.busy_res && res_q.tone_event == qtes_pkg::EV_OFF))
    else $error("begin did not clear the queue and the playing effect");

endmodule

[verif/queued_tone_effect_sequencer_tb.sv]
`timescale 1ns / 100ps

module queued_tone_effect_sequencer_tb;

  localparam int unsigned NUM_WORDS = 1350;

  // Step table, listed from the first step of the first effect onward.
  localparam logic [29*16-1:0] NOTE_HZ = {
    16'd2000,
    16'd2600, 16'd3300,
    16'd180,
    16'd880,  16'd1175, 16'd1568, 16'd2093, 16'd2637,
    16'd2637, 16'd2093, 16'd1568, 16'd1175, 16'd880,
    16'd2200, 16'd0,    16'd2200,
    16'd3100, 16'd420,  16'd2600, 16'd520,  16'd3400, 16'd330,
    16'd3600,
    16'd1046, 16'd1318, 16'd1568, 16'd2093, 16'd2637
  };
  localparam logic [29*8-1:0] NOTE_MS = {
    8'd60,
    8'd25, 8'd25,
    8'd140,
    8'd40, 8'd40, 8'd40, 8'd40, 8'd40,
    8'd40, 8'd40, 8'd40, 8'd40, 8'd40,
    8'd45, 8'd45, 8'd45,
    8'd25, 8'd25, 8'd25, 8'd25, 8'd25, 8'd25,
    8'd12,
    8'd45, 8'd45, 8'd45, 8'd45, 8'd140
  };
  localparam logic [10*5-1:0] FIRST_NOTE = {
    5'd0, 5'd0, 5'd1, 5'd3, 5'd4, 5'd9, 5'd14, 5'd17, 5'd23, 5'd24
  };
  localparam logic [10*3-1:0] NOTE_COUNT = {
    3'd0, 3'd1, 3'd2, 3'd1, 3'd5, 3'd5, 3'd3, 3'd6, 3'd1, 3'd5
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  qtes_pkg::in_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  qtes_pkg::out_t out_word;

  qtes_pkg::in_t pending_words[$];
  qtes_pkg::out_t tone_results_due[$];

  int unsigned words_planned = 0;
  int unsigned words_sent = 0;
  int unsigned results_seen = 0;
  int unsigned plays_queued = 0;
  int unsigned tones_started = 0;
  int unsigned errors = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  logic quiet_run = 1'b0;

  logic [3:0] fifo [0:3];
  logic [1:0] fifo_head = '0;
  logic [2:0] fifo_cnt = '0;
  logic [3:0] playing = '0;
  logic [2:0] step_no = '0;
  logic [31:0] step_stamp = '0;
  logic pin_on = 1'b0;
  qtes_pkg::out_t tone_now;

  queued_tone_effect_sequencer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic [4:0] first_note(input logic [3:0] eff);
    return FIRST_NOTE[(9 - eff) * 5 +: 5];
  endfunction

  function automatic void silence_pin();
    pin_on = 1'b0;
    tone_now.tone_event = qtes_pkg::EV_OFF;
    tone_now.tone_hz = '0;
  endfunction

  function automatic void sound_note(input logic [4:0] idx);
    logic [15:0] hz;
    hz = NOTE_HZ[(28 - idx) * 16 +: 16];
    if (hz == 16'd0) begin
      silence_pin();
    end else begin
      pin_on = 1'b1;
      tone_now.tone_event = qtes_pkg::EV_ON;
      tone_now.tone_hz = hz;
    end
  endfunction

  function automatic void drop_effect();
    playing = '0;
    step_no = '0;
    silence_pin();
  endfunction

  function automatic void silence_all();
    fifo_head = '0;
    fifo_cnt = '0;
    if (playing != 4'd0 || pin_on) begin
      drop_effect();
    end
  endfunction

  function automatic qtes_pkg::out_t predict_tone_result(input qtes_pkg::in_t w);
    logic [4:0] idx;
    logic [2:0] nxt;
    logic [1:0] slot;
    logic [31:0] elapsed;
    tone_now = '0;
    case (w.cmd)
      qtes_pkg::CMD_TICK: begin
        if (w.muted) begin
          silence_all();
        end else if (playing == 4'd0) begin
          if (fifo_cnt != 3'd0) begin
            playing = fifo[fifo_head];
            fifo_head = fifo_head + 2'd1;
            fifo_cnt = fifo_cnt - 3'd1;
            step_no = '0;
            step_stamp = w.now_ms;
            sound_note(first_note(playing));
          end
        end else begin
          idx = first_note(playing) + {2'd0, step_no};
          elapsed = w.now_ms - step_stamp;
          if (elapsed >= {24'd0, NOTE_MS[(28 - idx) * 8 +: 8]}) begin
            nxt = step_no + 3'd1;
            if (nxt >= NOTE_COUNT[(9 - playing) * 3 +: 3]) begin
              drop_effect();
            end else begin
              step_no = nxt;
              step_stamp = w.now_ms;
              sound_note(idx + 5'd1);
            end
          end
        end
      end
      qtes_pkg::CMD_PLAY: begin
        if (w.effect_id != 4'd0 && w.effect_id < qtes_pkg::NUM_EFFECTS && !w.muted &&
            fifo_cnt < qtes_pkg::QUEUE_DEPTH) begin
          slot = fifo_head + fifo_cnt[1:0];
          fifo[slot] = w.effect_id;
          fifo_cnt = fifo_cnt + 3'd1;
          tone_now.accepted = 1'b1;
        end
      end
      qtes_pkg::CMD_STOP: begin
        silence_all();
      end
      default: begin
        fifo_head = '0;
        fifo_cnt = '0;
        playing = '0;
        step_no = '0;
        step_stamp = '0;
        silence_pin();
      end
    endcase
    tone_now.busy_res = (playing != 4'd0);
    tone_now.queued = fifo_cnt;
    return tone_now;
  endfunction

  function automatic int unsigned draw_wait();
    return quiet_run ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  task automatic send_word(input qtes_pkg::cmd_e c, input logic [3:0] eff,
                           input logic [31:0] ms, input logic m);
    qtes_pkg::in_t w;
    w.cmd = c;
    w.effect_id = eff;
    w.now_ms = ms;
    w.muted = m;
    pending_words.push_back(w);
    words_planned++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_word <= '0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        tone_results_due.push_back(predict_tone_result(in_word));
        words_sent++;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          in_word <= pending_words.pop_front();
          in_valid <= 1'b1;
          gap_left <= draw_wait();
          if ($urandom_range(0, 59) == 0) begin
            quiet_run <= !quiet_run;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : result_check
    int unsigned hold;
    qtes_pkg::out_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      hold = stall_left;
      if (out_valid && !out_stall) begin
        results_seen++;
        if (tone_results_due.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %h", $time, out_word);
          errors++;
        end else begin
          want = tone_results_due.pop_front();
          compare_field("accepted", 32'(want.accepted), 32'(out_word.accepted));
          compare_field("tone_event", 32'(want.tone_event), 32'(out_word.tone_event));
          compare_field("tone_hz", 32'(want.tone_hz), 32'(out_word.tone_hz));
          compare_field("busy_res", 32'(want.busy_res), 32'(out_word.busy_res));
          compare_field("queued", 32'(want.queued), 32'(out_word.queued));
          if (want.accepted) plays_queued++;
          if (want.tone_event == qtes_pkg::EV_ON) tones_started++;
        end
        hold = draw_wait();
      end else if (hold != 0) begin
        hold = hold - 1;
      end
      stall_left <= hold;
      out_stall <= (hold != 0);
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int unsigned pick;
    int unsigned n;
    logic [31:0] clock_ms;
    logic [3:0] eff;

    send_word(qtes_pkg::CMD_BEGIN, 4'hF, 32'hFFFF_FFFF, 1'b1);
    send_word(qtes_pkg::CMD_TICK, 4'h0, 32'h0, 1'b0);
    send_word(qtes_pkg::CMD_PLAY, 4'd0, 32'h0, 1'b0);
    send_word(qtes_pkg::CMD_PLAY, 4'd10, 32'h0, 1'b0);
    send_word(qtes_pkg::CMD_PLAY, 4'd15, 32'h0, 1'b0);
    send_word(qtes_pkg::CMD_PLAY, 4'd3, 32'h0, 1'b1);
    send_word(qtes_pkg::CMD_PLAY, 4'd9, 32'h0, 1'b0);
    send_word(qtes_pkg::CMD_PLAY, 4'd1, 32'h0, 1'b0);
    send_word(qtes_pkg::CMD_PLAY, 4'd2, 32'h0, 1'b0);
    send_word(qtes_pkg::CMD_PLAY, 4'd4, 32'h0, 1'b0);
    send_word(qtes_pkg::CMD_PLAY, 4'd5, 32'h0, 1'b0);
    // Time wraps between these ticks; one short of the step length, then exactly it.
    send_word(qtes_pkg::CMD_TICK, 4'd0, 32'hFFFF_FFF0, 1'b0);
    send_word(qtes_pkg::CMD_TICK, 4'd0, 32'h0000_001C, 1'b0);
    send_word(qtes_pkg::CMD_TICK, 4'd0, 32'h0000_001D, 1'b0);
    send_word(qtes_pkg::CMD_TICK, 4'd0, 32'h8000_0000, 1'b0);
    send_word(qtes_pkg::CMD_PLAY, 4'd6, 32'h0, 1'b0);
    send_word(qtes_pkg::CMD_STOP, 4'd7, 32'h1234_5678, 1'b1);
    send_word(qtes_pkg::CMD_STOP, 4'd0, 32'h0, 1'b0);
    send_word(qtes_pkg::CMD_PLAY, 4'd6, 32'h0, 1'b0);
    send_word(qtes_pkg::CMD_TICK, 4'd0, 32'd100, 1'b0);
    send_word(qtes_pkg::CMD_TICK, 4'd0, 32'd145, 1'b0);
    send_word(qtes_pkg::CMD_TICK, 4'd0, 32'd190, 1'b0);
    send_word(qtes_pkg::CMD_TICK, 4'd0, 32'd235, 1'b0);
    send_word(qtes_pkg::CMD_PLAY, 4'd8, 32'h0, 1'b0);
    send_word(qtes_pkg::CMD_TICK, 4'd0, 32'd300, 1'b0);
    send_word(qtes_pkg::CMD_TICK, 4'd0, 32'd301, 1'b1);
    send_word(qtes_pkg::CMD_TICK, 4'd0, 32'd302, 1'b1);

    clock_ms = $urandom;
    while (words_planned < NUM_WORDS + 27) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          eff = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(1, 9));
          send_word(qtes_pkg::CMD_PLAY, eff, $urandom, $urandom_range(0, 19) == 0);
        end
      end else if (pick < 93) begin
        n = $urandom_range(3, 30);
        repeat (n) begin
          pick = $urandom_range(0, 99);
          if (pick < 60) begin
            clock_ms = clock_ms + $urandom_range(0, 50);
          end else if (pick < 90) begin
            clock_ms = clock_ms + $urandom_range(0, 160);
          end else if (pick >= 97) begin
            clock_ms = $urandom;
          end
          send_word(qtes_pkg::CMD_TICK, 4'($urandom_range(0, 15)), clock_ms,
                    $urandom_range(0, 39) == 0);
        end
      end else if (pick < 98) begin
        send_word(qtes_pkg::CMD_STOP, 4'($urandom_range(0, 15)), $urandom,
                  1'($urandom_range(0, 1)));
      end else begin
        send_word(qtes_pkg::CMD_BEGIN, 4'($urandom_range(0, 15)), $urandom,
                  1'($urandom_range(0, 1)));
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_words.size() != 0 || in_valid) @(posedge clk_i);
    while (tone_results_due.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);

    $display("Sent %0d command words and checked %0d result words.", words_sent, results_seen);
    $display("Plays queued: %0d, tone starts: %0d, mismatches: %0d.",
             plays_queued, tones_started, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/qtes_pkg.sv
rtl/core/qtes_queue.sv
rtl/core/qtes_player.sv
rtl/core/queued_tone_effect_sequencer.sv
verif/queued_tone_effect_sequencer_tb.sv
